// ===== sv/hsv_pkg.sv =====
// shared types and constants for the hsv to rgb converter
`default_nettype none

package hsv_pkg;

  // input field limits
  localparam logic [12:0] HUE_WRAP    = 13'd5760;
  localparam logic [9:0]  SECTOR_SPAN = 10'd960;
  localparam logic [8:0]  UNIT        = 9'd256;

  // 256 * 960: the full-scale numerator for one channel
  localparam logic [17:0] FULL_K      = 18'd245760;

  // floor(h / 15) == (h * 4370) >> 16 for every h below 3826
  localparam logic [12:0] RECIP15     = 13'd4370;

  // pipeline depth, output register included
  localparam int unsigned NUM_STAGES  = 5;

  // what each channel takes from the sector: v, q, t or p
  typedef logic [1:0] chan_sel_t;
  localparam chan_sel_t SEL_V = 2'd0;  // subtract nothing
  localparam chan_sel_t SEL_Q = 2'd1;  // subtract sat * rem
  localparam chan_sel_t SEL_T = 2'd2;  // subtract sat * (960 - rem)
  localparam chan_sel_t SEL_P = 2'd3;  // subtract sat * 960

  // first stage result
  typedef struct packed {
    chan_sel_t  sel_red;
    chan_sel_t  sel_green;
    chan_sel_t  sel_blue;
    logic [9:0] rem;
    logic [8:0] sat;
    logic [8:0] val;
  } sector_t;

  // load enables for the channel stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== sv/hsv_sector.sv =====
// first stage: clamp inputs, wrap hue, find sector and remainder
`default_nettype none

module hsv_sector import hsv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [12:0] hue,
  input  wire logic [8:0]  saturation,
  input  wire logic [8:0]  brightness,
  output sector_t          sec
);

  localparam logic [2:0] SEC0 = 3'd0;
  localparam logic [2:0] SEC1 = 3'd1;
  localparam logic [2:0] SEC2 = 3'd2;
  localparam logic [2:0] SEC3 = 3'd3;
  localparam logic [2:0] SEC4 = 3'd4;
  localparam logic [2:0] SEC5 = 3'd5;

  logic [12:0] hue_w;
  logic [2:0]  sector;
  logic [12:0] base;
  logic [12:0] rem_full;
  sector_t     sec_nxt;
  sector_t     sec_r;

  // hue at or above 360 degrees acts as zero
  assign hue_w = (hue >= HUE_WRAP) ? 13'd0 : hue;

  // sector from parallel compares against multiples of 60 degrees
  always_comb begin
    if (hue_w >= 13'd4800) begin
      sector = SEC5;
    end else if (hue_w >= 13'd3840) begin
      sector = SEC4;
    end else if (hue_w >= 13'd2880) begin
      sector = SEC3;
    end else if (hue_w >= 13'd1920) begin
      sector = SEC2;
    end else if (hue_w >= 13'd960) begin
      sector = SEC1;
    end else begin
      sector = SEC0;
    end
  end

  // sector decode: start of the sector and channel selection
  always_comb begin
    sec_nxt = '0;
    base    = 13'd0;
    unique case (sector)
      SEC0: begin
        base = 13'd0;
        sec_nxt.sel_red = SEL_V; sec_nxt.sel_green = SEL_T; sec_nxt.sel_blue = SEL_P;
      end
      SEC1: begin
        base = 13'd960;
        sec_nxt.sel_red = SEL_Q; sec_nxt.sel_green = SEL_V; sec_nxt.sel_blue = SEL_P;
      end
      SEC2: begin
        base = 13'd1920;
        sec_nxt.sel_red = SEL_P; sec_nxt.sel_green = SEL_V; sec_nxt.sel_blue = SEL_T;
      end
      SEC3: begin
        base = 13'd2880;
        sec_nxt.sel_red = SEL_P; sec_nxt.sel_green = SEL_Q; sec_nxt.sel_blue = SEL_V;
      end
      SEC4: begin
        base = 13'd3840;
        sec_nxt.sel_red = SEL_T; sec_nxt.sel_green = SEL_P; sec_nxt.sel_blue = SEL_V;
      end
      default: begin
        base = 13'd4800;
        sec_nxt.sel_red = SEL_V; sec_nxt.sel_green = SEL_P; sec_nxt.sel_blue = SEL_Q;
      end
    endcase
    rem_full      = hue_w - base;
    sec_nxt.rem   = rem_full[9:0];
    // saturation and value clamp to 1.0
    sec_nxt.sat   = (saturation > UNIT) ? UNIT : saturation;
    sec_nxt.val   = (brightness > UNIT) ? UNIT : brightness;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (en) begin
      sec_r <= sec_nxt;
    end
  end

  assign sec = sec_r;

endmodule

`default_nettype wire

// ===== sv/hsv_chan.sv =====
// one colour channel: weight, scale by value, times 255, divide by 2^21 * 30
`default_nettype none

module hsv_chan import hsv_pkg::*; (
  input  wire logic       clk,
  input  wire stage_en_t  en,
  input  wire chan_sel_t  sel,
  input  wire logic [9:0] rem,
  input  wire logic [8:0] sat,
  input  wire logic [8:0] val,
  output logic      [7:0] chan
);

  logic [9:0]  x;
  logic [17:0] sx;
  logic [17:0] k_nxt;
  logic [17:0] k_r;
  logic [8:0]  val_r;
  logic [26:0] m_full;
  logic [25:0] m_r;
  logic [33:0] n;
  logic [12:0] q_r;
  logic [11:0] h;
  logic [24:0] d_full;
  logic [7:0]  chan_r;

  // stage 2: k = 245760 - sat * x
  always_comb begin
    case (sel)
      SEL_V:   x = 10'd0;
      SEL_Q:   x = rem;
      SEL_T:   x = SECTOR_SPAN - rem;
      default: x = SECTOR_SPAN;
    endcase
    sx    = 18'(sat * x);
    k_nxt = FULL_K - sx;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      k_r   <= k_nxt;
      val_r <= val;
    end
  end

  // stage 3: numerator over 256 * 245760
  assign m_full = val_r * k_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      m_r <= m_full[25:0];
    end
  end

  // stage 4: times 255, drop the power-of-two part of the denominator
  assign n = {m_r, 8'd0} - {8'd0, m_r};

  always_ff @(posedge clk) begin
    if (en.s4) begin
      q_r <= n[33:21];
    end
  end

  // stage 5: divide by 30 as a halving and a reciprocal of 15
  assign h      = q_r[12:1];
  assign d_full = h * RECIP15;

  always_ff @(posedge clk) begin
    if (en.s5) begin
      chan_r <= d_full[23:16];
    end
  end

  assign chan = chan_r;

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgb_converter.sv =====
// top level: hsv to rgb converter, five-stage pipeline with stream handshakes
//
//   channel | direction | tdata fields (lowest bit up)
//   in_     | input     | hue[12:0], saturation[21:13], brightness[30:22]
//   out_    | output    | red[7:0], green[15:8], blue[23:16]
//
// one transaction per cycle unless back-pressure on out_tready fills the pipeline
// each result passes through the five register stages: sector, weight, value product,
// times 255, divide by 30 (the last is the output register)
// synchronous active-low reset clears the stage valid bits only
// each stage loads when it is empty or the next stage moves, so bubbles
// close up under back-pressure and nothing is dropped or repeated
`default_nettype none

module hsv_to_rgb_converter import hsv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // hue, saturation, brightness, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata   // red, green, blue
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] ld;
  stage_en_t             en;
  sector_t               sec;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;

  // load enables ripple back from the output
  always_comb begin
    ld[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ld[i] = !valid_r[i] || ld[i+1];
    end
  end

  assign en.s2 = ld[1];
  assign en.s3 = ld[2];
  assign en.s4 = ld[3];
  assign en.s5 = ld[4];

  // valid bits travel with the data
  always_comb begin
    valid_nxt[0] = ld[0] ? in_tvalid : valid_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      valid_nxt[i] = ld[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stage 1
  hsv_sector u_sector (
    .clk        (clk),
    .en         (ld[0]),
    .hue        (in_tdata[12:0]),
    .saturation (in_tdata[21:13]),
    .brightness (in_tdata[30:22]),
    .sec        (sec)
  );

  // stages 2 to 5, one lane per channel
  hsv_chan u_red (
    .clk  (clk),
    .en   (en),
    .sel  (sec.sel_red),
    .rem  (sec.rem),
    .sat  (sec.sat),
    .val  (sec.val),
    .chan (red)
  );

  hsv_chan u_green (
    .clk  (clk),
    .en   (en),
    .sel  (sec.sel_green),
    .rem  (sec.rem),
    .sat  (sec.sat),
    .val  (sec.val),
    .chan (green)
  );

  hsv_chan u_blue (
    .clk  (clk),
    .en   (en),
    .sel  (sec.sel_blue),
    .rem  (sec.rem),
    .sat  (sec.sat),
    .val  (sec.val),
    .chan (blue)
  );

  // ports
  assign in_tready  = ld[0];
  assign out_tvalid = valid_r[NUM_STAGES-1];
  assign out_tdata  = {blue, green, red};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the hsv to rgb converter stream block
`timescale 1ns / 1ps

module tb_top;
  import hsv_pkg::*;

  // hue sectors of sixty degrees each
  localparam int unsigned SECT_RED_YELLOW  = 0;
  localparam int unsigned SECT_YELLOW_GRN  = 1;
  localparam int unsigned SECT_GRN_CYAN    = 2;
  localparam int unsigned SECT_CYAN_BLUE   = 3;
  localparam int unsigned SECT_BLUE_MAGENTA = 4;

  localparam longint unsigned HUE_LIMIT = 5760;
  localparam longint unsigned SPAN      = 960;
  localparam longint unsigned ONE       = 256;
  localparam longint unsigned FULL      = ONE * SPAN;
  localparam longint unsigned DIVISOR   = ONE * ONE * SPAN;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // hue[12:0], saturation[21:13], brightness[30:22]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // red[7:0], green[15:8], blue[23:16]

  rgb_t        pending_rgb[$];
  int unsigned errors_seen = 0;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;

  hsv_to_rgb_converter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // free-running clock, 2 ns period
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit well above the slowest correct run
  initial begin
    #400000;
    $display("tb_top: errors");
    $finish;
  end

  // floor of channel numerator times 255 over the common denominator
  function automatic logic [7:0] scale255(longint unsigned num);
    longint unsigned prod;
    prod = (num * 255) / DIVISOR;
    return prod[7:0];
  endfunction

  // exact rational hsv to rgb conversion, one floor per channel
  function automatic rgb_t convert_hsv(logic [12:0] hue_in, logic [8:0] sat_in,
                                       logic [8:0] val_in);
    longint unsigned h, s, v, nv, np, nq, nt, nr, ng, nb, sector, rem;
    rgb_t res;
    h = hue_in;
    s = sat_in;
    v = val_in;
    if (s > ONE) s = ONE;
    if (v > ONE) v = ONE;
    if (h >= HUE_LIMIT) h = 0;
    nv = v * FULL;
    if (s == 0) begin
      nr = nv; ng = nv; nb = nv;
    end else begin
      sector = h / SPAN;
      rem    = h % SPAN;
      np = v * (ONE - s) * SPAN;
      nq = v * (FULL - s * rem);
      nt = v * (FULL - s * (SPAN - rem));
      case (sector)
        SECT_RED_YELLOW:   begin nr = nv; ng = nt; nb = np; end
        SECT_YELLOW_GRN:   begin nr = nq; ng = nv; nb = np; end
        SECT_GRN_CYAN:     begin nr = np; ng = nv; nb = nt; end
        SECT_CYAN_BLUE:    begin nr = np; ng = nq; nb = nv; end
        SECT_BLUE_MAGENTA: begin nr = nt; ng = np; nb = nv; end
        default:           begin nr = nv; ng = np; nb = nq; end
      endcase
    end
    res.red   = scale255(nr);
    res.green = scale255(ng);
    res.blue  = scale255(nb);
    return res;
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_pct == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each result transaction with the oldest expected colour
  always @(posedge clk) begin
    rgb_t want, got;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.red   = out_tdata[7:0];
      got.green = out_tdata[15:8];
      got.blue  = out_tdata[23:16];
      if (pending_rgb.size() == 0) begin
        $error("unexpected result transaction %h", out_tdata);
        errors_seen++;
      end else begin
        want = pending_rgb.pop_front();
        if (got.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red);
          errors_seen++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green);
          errors_seen++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue);
          errors_seen++;
        end
      end
    end
  end

  // drive one pixel, with random idle cycles ahead of it
  task automatic send_pixel(logic [12:0] hue, logic [8:0] sat, logic [8:0] val);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, sat, hue};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_rgb.push_back(convert_hsv(hue, sat, val));
  endtask

  // hold the input off until every result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (NUM_STAGES * 3) @(posedge clk);
  endtask

  // field extremes and sector boundaries
  task automatic test_corners();
    send_pixel(13'd0, 9'd256, 9'd256);
    send_pixel(13'd0, 9'd0, 9'd0);
    send_pixel(13'd959, 9'd256, 9'd256);
    send_pixel(13'd960, 9'd256, 9'd256);
    send_pixel(13'd1920, 9'd128, 9'd200);
    send_pixel(13'd2880, 9'd1, 9'd256);
    send_pixel(13'd3840, 9'd255, 9'd255);
    send_pixel(13'd4799, 9'd256, 9'd1);
    send_pixel(13'd4800, 9'd200, 9'd256);
    send_pixel(13'd5759, 9'd256, 9'd256);
    send_pixel(13'd1, 9'd1, 9'd1);
  endtask

  // hue wrap, gray, and clamping of saturation and brightness
  task automatic test_special_cases();
    send_pixel(13'd5760, 9'd256, 9'd256);
    send_pixel(13'd8191, 9'd180, 9'd256);
    send_pixel(13'd6000, 9'd511, 9'd511);
    send_pixel(13'd2000, 9'd0, 9'd256);
    send_pixel(13'd4000, 9'd0, 9'd511);
    send_pixel(13'd3000, 9'd0, 9'd77);
    send_pixel(13'd1500, 9'd257, 9'd100);
    send_pixel(13'd1500, 9'd511, 9'd100);
    send_pixel(13'd3500, 9'd128, 9'd257);
    send_pixel(13'd3500, 9'd128, 9'd511);
    send_pixel(13'd7000, 9'd0, 9'd0);
  endtask

  function automatic logic [8:0] pick_level();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 9'($urandom_range(256));
    if (r < 80) return 9'd0;
    if (r < 88) return 9'd256;
    return 9'($urandom_range(511));
  endfunction

  // random pixels under one idle and stall setting
  task automatic test_random_stream(int unsigned count, int unsigned idle,
                                    int unsigned stall);
    logic [12:0] hue;
    int unsigned r;
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 70) hue = 13'($urandom_range(5759));
      else if (r < 80) hue = 13'($urandom_range(5) * 960 + $urandom_range(2)) - 13'd1;
      else if (r < 88) hue = 13'($urandom_range(8191, 5760));
      else hue = 13'($urandom);
      send_pixel(hue, pick_level(), pick_level());
    end
  endtask

  // stimulus sequence
  initial begin
    idle_pct  = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_special_cases();
    test_random_stream(457, 0, 0);
    wait_drained();
    test_random_stream(457, 63, 0);
    test_random_stream(457, 0, 63);
    wait_drained();
    test_random_stream(457, 27, 27);
    stall_pct = 0;
    wait_drained();
    if (errors_seen == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
